/* sv/slm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_pkg: shared types and constants for the sorted list merge core
// record layout, operation and command codes, list and queue sizing
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int OP_W   = 2;
  localparam int SUBJ_W = 20;
  localparam int STUD_W = 27;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE       = 2'd2;

  localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [1:0] CMD_MERGE       = 2'd2;

  typedef struct packed {
    logic [SUBJ_W-1:0] subject;
    logic [STUD_W-1:0] student;
  } rec_t;

  typedef struct packed {
    logic [1:0] kind;
    rec_t       rec;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

/* sv/slm_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_in_if: input transaction channel
// operation code plus the record to load
// ----------------------------------------------------------------------------
interface slm_in_if;
  logic                         valid;
  logic                         ready;
  logic [slm_pkg::OP_W-1:0]     operation;
  logic [slm_pkg::SUBJ_W-1:0]   subject_code;
  logic [slm_pkg::STUD_W-1:0]   student_number;

  modport source (output valid, operation, subject_code, student_number, input ready);
  modport sink   (input valid, operation, subject_code, student_number, output ready);
endinterface

/* sv/slm_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_out_if: output transaction channel
// one merged record per transaction, last flag on the final one
// ----------------------------------------------------------------------------
interface slm_out_if;
  logic                         valid;
  logic                         ready;
  logic [slm_pkg::SUBJ_W-1:0]   out_subject_code;
  logic [slm_pkg::STUD_W-1:0]   out_student_number;
  logic                         last_record;

  modport source (output valid, out_subject_code, out_student_number, last_record,
                  input ready);
  modport sink   (input valid, out_subject_code, out_student_number, last_record,
                  output ready);
endinterface

/* sv/sorted_list_merge_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_merge_core: two-way merge of two sorted record lists
// loads records into two lists and emits them merged by ascending subject code
// ----------------------------------------------------------------------------
//  channel   dir   payload                                               transaction
//  items     in    operation, subject_code, student_number               load or merge
//  records   out   out_subject_code, out_student_number, last_record     merged record
//
//  loads are taken one per cycle while no merge runs; a merge first fetches
//  the list heads from the registered-read list memories, then emits one
//  record per cycle from the head compare
//  items are decoded into a two-entry command queue; input stalls once both
//  entries wait behind a running merge, and a merge stalls on records.ready
//  rst is synchronous; list memories need no clearing, counts reset to zero
// ----------------------------------------------------------------------------
module sorted_list_merge_core (
  input  logic       clk,
  input  logic       rst,
  slm_in_if.sink     items,
  slm_out_if.source  records
);

  slm_pkg::fifo_status_t  fifo_status;
  slm_pkg::cmd_t          push_cmd;
  slm_pkg::cmd_t          head_cmd;
  logic                   push;
  logic                   pop;

  slm_front u_front (
    .items       (items),
    .fifo_status (fifo_status),
    .push        (push),
    .cmd         (push_cmd)
  );

  slm_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (fifo_status)
  );

  slm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .fifo_status (fifo_status),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .records     (records)
  );

endmodule

/* sv/slm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_front: input decode
// accepts transactions, turns operation codes into commands, drops unknown ones
// ----------------------------------------------------------------------------
module slm_front (
  slm_in_if.sink                 items,
  input  slm_pkg::fifo_status_t  fifo_status,
  output logic                   push,
  output slm_pkg::cmd_t          cmd
);

  logic cmd_ok;

  always_comb begin
    cmd.rec.subject = items.subject_code;
    cmd.rec.student = items.student_number;
    cmd.kind        = slm_pkg::CMD_MERGE;
    cmd_ok          = 1'b1;
    case (items.operation)
      slm_pkg::OP_LOAD_FIRST:  cmd.kind = slm_pkg::CMD_LOAD_FIRST;
      slm_pkg::OP_LOAD_SECOND: cmd.kind = slm_pkg::CMD_LOAD_SECOND;
      slm_pkg::OP_MERGE:       cmd.kind = slm_pkg::CMD_MERGE;
      default:                 cmd_ok   = 1'b0;
    endcase
  end

  assign items.ready = !fifo_status.full;
  assign push        = items.valid && !fifo_status.full && cmd_ok;

endmodule

/* sv/slm_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_cmd_fifo: command queue
// short queue between decode and execution
// ----------------------------------------------------------------------------
module slm_cmd_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  slm_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output slm_pkg::cmd_t          head_cmd,
  output slm_pkg::fifo_status_t  status
);

  slm_pkg::cmd_t                entries [slm_pkg::FIFO_DEPTH];
  logic [slm_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [slm_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [slm_pkg::FIFO_AW:0]    fill;
  logic                         do_push;
  logic                         do_pop;

  assign status.full  = (fill == (slm_pkg::FIFO_AW + 1)'(slm_pkg::FIFO_DEPTH));
  assign status.empty = (fill == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* sv/slm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_back: list storage and merge sequencer
// stores both lists, walks their heads and, unless records.ready stalls it, emits one record per cycle
// ----------------------------------------------------------------------------
module slm_back (
  input  logic                   clk,
  input  logic                   rst,
  input  slm_pkg::fifo_status_t  fifo_status,
  input  slm_pkg::cmd_t          head_cmd,
  output logic                   pop,
  slm_out_if.source              records
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  slm_pkg::rec_t               mem_a [slm_pkg::LIST_DEPTH];
  slm_pkg::rec_t               mem_b [slm_pkg::LIST_DEPTH];
  slm_pkg::rec_t               rd_a;
  slm_pkg::rec_t               rd_b;
  slm_pkg::rec_t               o_rec;
  logic                        o_valid;
  logic                        o_last;
  logic                        state;
  logic [slm_pkg::CNT_W-1:0]   cnt_a;
  logic [slm_pkg::CNT_W-1:0]   cnt_b;
  logic [slm_pkg::CNT_W-1:0]   ia;
  logic [slm_pkg::CNT_W-1:0]   ib;
  logic [slm_pkg::CNT_W-1:0]   ia_next;
  logic [slm_pkg::CNT_W-1:0]   ib_next;
  logic                        o_load;
  logic                        take_a;
  logic                        have_a;
  logic                        have_b;
  logic                        merge_done;
  logic                        wr_a;
  logic                        wr_b;
  logic                        start_merge;

  always_comb begin
    pop         = (state == ST_IDLE) && !fifo_status.empty;
    wr_a        = pop && (head_cmd.kind == slm_pkg::CMD_LOAD_FIRST)
                  && (cnt_a < slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH));
    wr_b        = pop && (head_cmd.kind == slm_pkg::CMD_LOAD_SECOND)
                  && (cnt_b < slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH));
    start_merge = pop && (head_cmd.kind == slm_pkg::CMD_MERGE)
                  && ((cnt_a != '0) || (cnt_b != '0));
    o_load      = (state == ST_MERGE) && (!o_valid || records.ready);
    have_a      = ia < cnt_a;
    have_b      = ib < cnt_b;
    take_a      = have_a && (!have_b || (rd_a.subject < rd_b.subject));
    ia_next     = ia;
    ib_next     = ib;
    if (o_load) begin
      if (take_a) begin
        ia_next = ia + 1'b1;
      end else begin
        ib_next = ib + 1'b1;
      end
    end
    merge_done = o_load && (ia_next >= cnt_a) && (ib_next >= cnt_b);
    if (merge_done) begin
      ia_next = '0;
      ib_next = '0;
    end
  end

  // list storage, read data registered at the next head position
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a[slm_pkg::IDX_W-1:0]] <= head_cmd.rec;
    end
    if (wr_b) begin
      mem_b[cnt_b[slm_pkg::IDX_W-1:0]] <= head_cmd.rec;
    end
    rd_a <= mem_a[ia_next[slm_pkg::IDX_W-1:0]];
    rd_b <= mem_b[ib_next[slm_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_rec  <= take_a ? rd_a : rd_b;
      o_last <= merge_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt_a   <= '0;
      cnt_b   <= '0;
      ia      <= '0;
      ib      <= '0;
      o_valid <= 1'b0;
    end else begin
      ia <= ia_next;
      ib <= ib_next;
      if (wr_a) begin
        cnt_a <= cnt_a + 1'b1;
      end
      if (wr_b) begin
        cnt_b <= cnt_b + 1'b1;
      end
      if (start_merge) begin
        state <= ST_MERGE;
      end
      if (merge_done) begin
        state <= ST_IDLE;
        cnt_a <= '0;
        cnt_b <= '0;
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (records.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign records.valid              = o_valid;
  assign records.out_subject_code   = o_rec.subject;
  assign records.out_student_number = o_rec.student;
  assign records.last_record        = o_last;

  a_merge_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |-> (have_a || have_b))
    else $error("merge running with both lists used up");

  a_lists_cleared: assert property (@(posedge clk) disable iff (rst)
    merge_done |=> (cnt_a == '0) && (cnt_b == '0) && (ia == '0) && (ib == '0))
    else $error("lists not emptied after merge");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt_a <= slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH))
    && (cnt_b <= slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH)))
    else $error("list count beyond depth");

  a_no_pop_in_merge: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |-> !pop)
    else $error("command taken while merge runs");

  a_heads_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (ia == '0) && (ib == '0))
    else $error("head index not at start while idle");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the sorted list merge core
// loads records into both lists with bursty input and a stalling record sink,
// predicts every merged record in a behavioral list model and checks each
// record transaction in order, field by field
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [slm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 2000;
  localparam int END_WAIT     = 40;
  localparam int ITEM_TARGET  = 170;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    slm_pkg::rec_t rec;
    logic          last;
  } merged_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slm_in_if  items_if ();
  slm_out_if records_if ();

  sorted_list_merge_core dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .records (records_if)
  );

  always #5 clk = ~clk;

  slm_pkg::rec_t first_held[$];
  slm_pkg::rec_t second_held[$];
  merged_rec_t   pending_records[$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int items_sent  = 0;
  int ready_mode  = 0;
  int ready_phase = 0;

  // list model, applied to each accepted transaction
  function automatic void update_lists(input logic [slm_pkg::OP_W-1:0] op,
                                       input logic [slm_pkg::SUBJ_W-1:0] subj,
                                       input logic [slm_pkg::STUD_W-1:0] stud);
    slm_pkg::rec_t r;
    merged_rec_t   m;
    int            i;
    int            j;
    r.subject = subj;
    r.student = stud;
    i = 0;
    j = 0;
    case (op)
      slm_pkg::OP_LOAD_FIRST: begin
        if (first_held.size() < slm_pkg::LIST_DEPTH) first_held.push_back(r);
      end
      slm_pkg::OP_LOAD_SECOND: begin
        if (second_held.size() < slm_pkg::LIST_DEPTH) second_held.push_back(r);
      end
      slm_pkg::OP_MERGE: begin
        while (i < first_held.size() || j < second_held.size()) begin
          if (j >= second_held.size() ||
              (i < first_held.size() &&
               first_held[i].subject < second_held[j].subject)) begin
            m.rec = first_held[i];
            i++;
          end else begin
            m.rec = second_held[j];
            j++;
          end
          m.last = (i == first_held.size()) && (j == second_held.size());
          pending_records.push_back(m);
        end
        first_held.delete();
        second_held.delete();
      end
      default: ;
    endcase
  endfunction

  function automatic logic [slm_pkg::SUBJ_W-1:0] random_code(input int style);
    logic [31:0] raw;
    case (style)
      0:       raw = $urandom_range(0, 2**slm_pkg::SUBJ_W - 1);
      1:       raw = $urandom_range(0, 7);
      2:       raw = $urandom_range(0, 999999);
      default: raw = $urandom_range(2**slm_pkg::SUBJ_W - 16, 2**slm_pkg::SUBJ_W - 1);
    endcase
    return raw[slm_pkg::SUBJ_W-1:0];
  endfunction

  function automatic logic [slm_pkg::STUD_W-1:0] random_student();
    logic [31:0] raw;
    raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99999999) : $urandom;
    return raw[slm_pkg::STUD_W-1:0];
  endfunction

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      items_if.valid <= 1'b0;
    end
  endtask

  task automatic send_item(input logic [slm_pkg::OP_W-1:0] op,
                           input logic [slm_pkg::SUBJ_W-1:0] subj,
                           input logic [slm_pkg::STUD_W-1:0] stud);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) pause(gap);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    @(negedge clk);
    items_if.valid          <= 1'b1;
    items_if.operation      <= op;
    items_if.subject_code   <= subj;
    items_if.student_number <= stud;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    burst_left--;
    update_lists(op, subj, stud);
    items_sent++;
  endtask

  task automatic wait_for_drain();
    pause(1);
    while (pending_records.size() != 0) @(posedge clk);
  endtask

  task automatic merge_round(input int nf, input int ns, input bit sorted_codes,
                             input bit noise);
    logic [slm_pkg::SUBJ_W-1:0] fq[$];
    logic [slm_pkg::SUBJ_W-1:0] sq[$];
    int                         style;
    style = $urandom_range(0, 3);
    repeat (nf) fq.push_back(random_code(style));
    repeat (ns) sq.push_back(random_code(style));
    if (sorted_codes) begin
      fq.sort();
      sq.sort();
    end
    while (fq.size() > 0 || sq.size() > 0) begin
      if (noise && $urandom_range(0, 5) == 0)
        send_item(OP_UNUSED, random_code(0), random_student());
      if (sq.size() == 0 || (fq.size() > 0 && $urandom_range(0, 1) == 1))
        send_item(slm_pkg::OP_LOAD_FIRST, fq.pop_front(), random_student());
      else
        send_item(slm_pkg::OP_LOAD_SECOND, sq.pop_front(), random_student());
    end
    send_item(slm_pkg::OP_MERGE, random_code(0), random_student());
  endtask

  task automatic test_empty_merge();
    send_item(slm_pkg::OP_MERGE, '1, '1);
    send_item(OP_UNUSED, '1, '1);
    send_item(slm_pkg::OP_MERGE, '0, '0);
    wait_for_drain();
  endtask

  // equal codes put the second list first
  task automatic test_extremes_and_ties();
    send_item(slm_pkg::OP_LOAD_FIRST, '0, '0);
    send_item(slm_pkg::OP_LOAD_SECOND, '0, 27'h5555555);
    send_item(OP_UNUSED, 20'h12345, 27'h1234567);
    send_item(slm_pkg::OP_LOAD_FIRST, '1, '1);
    send_item(slm_pkg::OP_LOAD_SECOND, '1, 27'h2AAAAAA);
    send_item(slm_pkg::OP_MERGE, 20'hAAAAA, 27'h7FFFFFF);
    wait_for_drain();
  endtask

  task automatic test_one_sided();
    send_item(slm_pkg::OP_LOAD_FIRST, 20'd100, 27'd1);
    send_item(slm_pkg::OP_LOAD_FIRST, 20'd200, 27'd2);
    send_item(slm_pkg::OP_LOAD_FIRST, 20'd999999, 27'd99999999);
    send_item(slm_pkg::OP_MERGE, '0, '0);
    send_item(slm_pkg::OP_LOAD_SECOND, 20'd7, 27'd3);
    send_item(slm_pkg::OP_LOAD_SECOND, 20'd7, 27'd4);
    send_item(slm_pkg::OP_MERGE, '0, '0);
    wait_for_drain();
  endtask

  task automatic test_unsorted();
    send_item(slm_pkg::OP_LOAD_FIRST, 20'd5, 27'd10);
    send_item(slm_pkg::OP_LOAD_FIRST, 20'd2, 27'd11);
    send_item(slm_pkg::OP_LOAD_SECOND, 20'd3, 27'd12);
    send_item(slm_pkg::OP_LOAD_SECOND, 20'd1, 27'd13);
    send_item(slm_pkg::OP_MERGE, '0, '0);
    wait_for_drain();
  endtask

  // one record past capacity on each side is dropped
  task automatic test_full_lists();
    merge_round(slm_pkg::LIST_DEPTH + 1, slm_pkg::LIST_DEPTH + 1, 1'b1, 1'b0);
    wait_for_drain();
  endtask

  task automatic test_random_merges();
    int nf;
    int ns;
    int kind;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      nf = ($urandom_range(0, 7) == 0) ?
           $urandom_range(14, slm_pkg::LIST_DEPTH + 2) : $urandom_range(0, 6);
      ns = ($urandom_range(0, 7) == 0) ?
           $urandom_range(14, slm_pkg::LIST_DEPTH + 2) : $urandom_range(0, 6);
      if (kind < 7)
        merge_round(nf, ns, 1'b1, kind == 0);
      else if (kind < 9)
        merge_round(nf, ns, 1'b0, 1'b1);
      else
        send_item(slm_pkg::OP_MERGE, random_code(0), random_student());
      if ($urandom_range(0, 5) == 0) wait_for_drain();
    end
    wait_for_drain();
  endtask

  // record sink stall pattern
  always @(negedge clk) begin
    if (ready_phase % 48 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0:       records_if.ready <= 1'b1;
      1:       records_if.ready <= 1'($urandom_range(0, 1));
      2:       records_if.ready <= ($urandom_range(0, 3) == 0);
      default: records_if.ready <= (ready_phase % 6) < 2;
    endcase
    ready_phase++;
  end

  // record checker
  always @(posedge clk) begin
    merged_rec_t want;
    if (!rst && records_if.valid && records_if.ready) begin
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected record transaction: subject %0d student %0d last %0b",
                   records_if.out_subject_code, records_if.out_student_number,
                   records_if.last_record);
      end else begin
        want = pending_records.pop_front();
        if (records_if.out_subject_code !== want.rec.subject ||
            records_if.out_student_number !== want.rec.student ||
            records_if.last_record !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected subject %0d student %0d last %0b, got %0d %0d %0b",
                     want.rec.subject, want.rec.student, want.last,
                     records_if.out_subject_code, records_if.out_student_number,
                     records_if.last_record);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (items_if.valid && items_if.ready) || (records_if.valid && records_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    items_if.valid          = 1'b0;
    items_if.operation      = slm_pkg::OP_LOAD_FIRST;
    items_if.subject_code   = '0;
    items_if.student_number = '0;
    records_if.ready        = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_empty_merge();
    test_extremes_and_ties();
    test_one_sided();
    test_unsorted();
    test_full_lists();
    test_random_merges();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
